// ----- src/cbu_pkg.sv -----
// Package for the 8080 branch unit: opcode codes, cycle counts,
// the registered input and result types, and the condition test.
// No dependencies.
package cbu_pkg;

  // Opcodes decoded as a whole byte
  localparam logic [7:0] OPC_CALL = 8'hCD;
  localparam logic [7:0] OPC_RET  = 8'hC9;
  localparam logic [7:0] OPC_PCHL = 8'hE9;
  localparam logic [7:0] OPC_JMP  = 8'hC3;

  // Opcode groups, matched after masking out the condition field
  localparam logic [7:0] GROUP_MASK   = 8'hC7;
  localparam logic [7:0] GRP_RST      = 8'hC7;
  localparam logic [7:0] GRP_CCC      = 8'hC4;
  localparam logic [7:0] GRP_RCC      = 8'hC0;
  localparam logic [7:0] GRP_JCC      = 8'hC2;
  localparam logic [7:0] RST_VEC_MASK = 8'h38;

  // Machine cycle counts
  localparam logic [4:0] CYC_NONE  = 5'd0;
  localparam logic [4:0] CYC_SHORT = 5'd5;
  localparam logic [4:0] CYC_JUMP  = 5'd10;
  localparam logic [4:0] CYC_MID   = 5'd11;
  localparam logic [4:0] CYC_CALL  = 5'd17;

  // Return address offsets and stack step
  localparam logic [15:0] LEN_ONE   = 16'd1;
  localparam logic [15:0] LEN_THREE = 16'd3;
  localparam logic [15:0] SP_STEP   = 16'd2;

  // Condition selectors (opcode bits 5:4 pick the flag)
  localparam logic [1:0] CSEL_ZERO   = 2'd0;
  localparam logic [1:0] CSEL_CARRY  = 2'd1;
  localparam logic [1:0] CSEL_PARITY = 2'd2;
  localparam logic [1:0] CSEL_SIGN   = 2'd3;

  typedef struct packed {
    logic [7:0]  mode;
    logic [15:0] immediate_address;
    logic [15:0] hl_value;
    logic        flag_zero;
    logic        flag_carry;
    logic        flag_parity;
    logic        flag_sign;
    logic [15:0] stack_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic        push_enable;
    logic [15:0] push_address;
    logic [15:0] push_word;
    logic        taken;
    logic [4:0]  cycles;
    logic        not_branch;
  } br_result_t;

  // Bit 0 of sel asks for the flag set, bits 2:1 choose the flag
  function automatic logic cond_holds(input logic [2:0] sel, input in_item_t it);
    logic f;
    case (sel[2:1])
      CSEL_ZERO:   f = it.flag_zero;
      CSEL_CARRY:  f = it.flag_carry;
      CSEL_PARITY: f = it.flag_parity;
      CSEL_SIGN:   f = it.flag_sign;
      default:     f = it.flag_sign;
    endcase
    return sel[0] ? f : ~f;
  endfunction

endpackage

// ----- src/cbu_if.sv -----
// Valid/ready channel interfaces for the branch unit: instruction input
// and result output. No dependencies.
interface cbu_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mode;
  logic [15:0] immediate_address;
  logic [15:0] hl_value;
  logic        flag_zero;
  logic        flag_carry;
  logic        flag_parity;
  logic        flag_sign;
  logic [15:0] stack_word;

  modport source (output valid, mode, immediate_address, hl_value, flag_zero,
                  flag_carry, flag_parity, flag_sign, stack_word,
                  input ready);
  modport sink   (input valid, mode, immediate_address, hl_value, flag_zero,
                  flag_carry, flag_parity, flag_sign, stack_word,
                  output ready);
endinterface

interface cbu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [15:0] next_sp;
  logic        push_enable;
  logic [15:0] push_address;
  logic [15:0] push_word;
  logic        taken;
  logic [4:0]  cycles;
  logic        not_branch;

  modport source (output valid, next_pc, next_sp, push_enable, push_address,
                  push_word, taken, cycles, not_branch, input ready);
  modport sink   (input valid, next_pc, next_sp, push_enable, push_address,
                  push_word, taken, cycles, not_branch, output ready);
endinterface

// ----- src/cbu_decode.sv -----
// Instruction decode and execute for one control-flow opcode against the
// current PC and SP. Depends on cbu_pkg.
module cbu_decode (
  input  cbu_pkg::in_item_t   item,
  input  logic [15:0]         pc,
  input  logic [15:0]         sp,
  output cbu_pkg::br_result_t res
);
  import cbu_pkg::*;

  logic [7:0]  grp;
  logic [2:0]  sel;
  logic        cond;
  logic [15:0] pc_plus1;
  logic [15:0] pc_plus3;
  logic [15:0] sp_down;
  logic [15:0] sp_up;

  assign grp      = item.mode & GROUP_MASK;
  assign sel      = item.mode[5:3];
  assign cond     = cond_holds(sel, item);
  assign pc_plus1 = pc + LEN_ONE;
  assign pc_plus3 = pc + LEN_THREE;
  assign sp_down  = sp - SP_STEP;
  assign sp_up    = sp + SP_STEP;

  // Tested in order: RST and CALL before the group matches
  always_comb begin
    res = '{next_pc: pc, next_sp: sp, push_enable: 1'b0, push_address: '0,
            push_word: '0, taken: 1'b0, cycles: CYC_NONE, not_branch: 1'b0};
    if (grp == GRP_RST) begin
      res.push_enable = 1'b1;
      res.push_word   = pc_plus1;
      res.next_pc     = {8'h00, item.mode & RST_VEC_MASK};
      res.taken       = 1'b1;
      res.cycles      = CYC_MID;
    end else if (item.mode == OPC_CALL) begin
      res.push_enable = 1'b1;
      res.push_word   = pc_plus3;
      res.next_pc     = item.immediate_address;
      res.taken       = 1'b1;
      res.cycles      = CYC_CALL;
    end else if (grp == GRP_CCC) begin
      if (cond) begin
        res.push_enable = 1'b1;
        res.push_word   = pc_plus3;
        res.next_pc     = item.immediate_address;
        res.taken       = 1'b1;
        res.cycles      = CYC_CALL;
      end else begin
        res.next_pc = pc_plus3;
        res.cycles  = CYC_MID;
      end
    end else if (item.mode == OPC_RET) begin
      res.next_pc = item.stack_word;
      res.next_sp = sp_up;
      res.taken   = 1'b1;
      res.cycles  = CYC_JUMP;
    end else if (grp == GRP_RCC) begin
      if (cond) begin
        res.next_pc = item.stack_word;
        res.next_sp = sp_up;
        res.taken   = 1'b1;
        res.cycles  = CYC_MID;
      end else begin
        res.next_pc = pc_plus1;
        res.cycles  = CYC_SHORT;
      end
    end else if (item.mode == OPC_PCHL) begin
      res.next_pc = item.hl_value;
      res.taken   = 1'b1;
      res.cycles  = CYC_SHORT;
    end else if (item.mode == OPC_JMP) begin
      res.next_pc = item.immediate_address;
      res.taken   = 1'b1;
      res.cycles  = CYC_JUMP;
    end else if (grp == GRP_JCC) begin
      res.next_pc = cond ? item.immediate_address : pc_plus3;
      res.taken   = cond;
      res.cycles  = CYC_JUMP;
    end else begin
      res.not_branch = 1'b1;
    end

    // Pushes lower SP and report the write address
    if (res.push_enable) begin
      res.push_address = sp_down;
      res.next_sp      = sp_down;
    end
  end

endmodule

// ----- src/cpu8080_branch_unit.sv -----
// Top level of the 8080 branch/call/return unit: input register, decode,
// result register, PC and SP. Depends on cbu_pkg, cbu_if and cbu_decode.
//
// Usage:
//   in_ch carries one control-flow instruction per transaction: the opcode,
//   the immediate target, HL, the four flags and the word at the stack top.
//   out_ch returns one result per transaction: next PC and SP, the stack
//   write request, taken, machine cycle count and not_branch.
//   An instruction accepted on in_ch sits in the input register and moves
//   into the result register, valid, once that register is empty or read.
//   Throughput is one instruction per cycle when out_ch does not stall;
//   PC and SP are updated as an instruction moves from the input register
//   into the result register, so the next one sees them straight away.
//   Reset clears PC, SP and both valid flags.
//   When out_ch stalls, the result register holds; one more instruction
//   waits in the input register, after which in_ch.ready drops.
module cpu8080_branch_unit (
  input  logic       clk,
  input  logic       rst_n,
  cbu_in_if.sink     in_ch,
  cbu_out_if.source  out_ch
);
  import cbu_pkg::*;

  in_item_t    s1_item_r;
  logic        s1_valid_r;
  br_result_t  res_r;
  br_result_t  res_nxt;
  logic        out_valid_r;
  logic [15:0] pc_r;
  logic [15:0] sp_r;
  logic        s1_adv;
  logic        in_fire;
  in_item_t    in_item;

  // Handshake control
  assign s1_adv      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_adv;
  assign in_fire     = in_ch.valid & in_ch.ready;

  assign in_item = '{mode: in_ch.mode, immediate_address: in_ch.immediate_address,
                     hl_value: in_ch.hl_value, flag_zero: in_ch.flag_zero,
                     flag_carry: in_ch.flag_carry, flag_parity: in_ch.flag_parity,
                     flag_sign: in_ch.flag_sign, stack_word: in_ch.stack_word};

  cbu_decode u_decode (
    .item (s1_item_r),
    .pc   (pc_r),
    .sp   (sp_r),
    .res  (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // Result register and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      sp_r        <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pc_r        <= res_nxt.next_pc;
        sp_r        <= res_nxt.next_sp;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  // Output channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_pc      = res_r.next_pc;
  assign out_ch.next_sp      = res_r.next_sp;
  assign out_ch.push_enable  = res_r.push_enable;
  assign out_ch.push_address = res_r.push_address;
  assign out_ch.push_word    = res_r.push_word;
  assign out_ch.taken        = res_r.taken;
  assign out_ch.cycles       = res_r.cycles;
  assign out_ch.not_branch   = res_r.not_branch;

endmodule
